// ----- rtl/tga_rle_pixel_decoder_unit_assert.svh -----
// ---------------------------------------------------------------------------
// TGA RLE pixel decoder assertion macros
// Concurrent checks on clk, disabled while rst_n is low; empty for synthesis.
// ---------------------------------------------------------------------------
`ifndef TGA_RLE_PIXEL_DECODER_UNIT_ASSERT_SVH
`define TGA_RLE_PIXEL_DECODER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define TGARLE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TGARLE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define TGARLE_ASSERT(lbl, prop, msg)
`define TGARLE_ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/tgarle_pkg.sv -----
// ---------------------------------------------------------------------------
// TGA RLE pixel decoder package
// Shared widths, reset values, register indexes, phase type and result type.
// ---------------------------------------------------------------------------
package tgarle_pkg;

    localparam int PIXEL_COUNT_WIDTH_DEF = 24;

    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 25;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PIXEL_BYTES  = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_HEADER_BYTES = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TOTAL_PIXELS = 2'd2;

    localparam logic [2:0]                PIXEL_BYTES_RST  = 3'd3;
    localparam logic [2:0]                PIXEL_BYTES_RGBA = 3'd4;
    localparam logic [15:0]               HEADER_BYTES_RST = 16'd18;
    localparam logic [CFG_DATA_WIDTH-1:0] TOTAL_PIXELS_RST = '0;
    localparam logic [7:0]                ALPHA_OPAQUE     = 8'd255;

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_HEADER = 2'd1,
        PH_PIXEL  = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0] chan0;
        logic [7:0] chan1;
        logic [7:0] chan2;
        logic [7:0] chan3;
        logic [7:0] run_length;
        logic       last_pixel;
        logic       overrun_error;
    } res_t;

endpackage

// ----- rtl/tgarle_in_if.sv -----
// ---------------------------------------------------------------------------
// TGA RLE byte input channel
// Valid/ready channel carrying one file byte and the start flag per item.
// ---------------------------------------------------------------------------
interface tgarle_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_of_image;

    modport source (output valid, output data_byte, output start_of_image, input ready);
    modport sink   (input valid, input data_byte, input start_of_image, output ready);
endinterface

// ----- rtl/tgarle_out_if.sv -----
// ---------------------------------------------------------------------------
// TGA RLE pixel output channel
// Valid/ready channel carrying one decoded pixel run per item.
// ---------------------------------------------------------------------------
interface tgarle_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] chan0;
    logic [7:0] chan1;
    logic [7:0] chan2;
    logic [7:0] chan3;
    logic [7:0] run_length;
    logic       last_pixel;
    logic       overrun_error;

    modport source (output valid, output chan0, output chan1, output chan2, output chan3,
                    output run_length, output last_pixel, output overrun_error,
                    input ready);
    modport sink   (input valid, input chan0, input chan1, input chan2, input chan3,
                    input run_length, input last_pixel, input overrun_error,
                    output ready);
endinterface

// ----- rtl/tgarle_cfg_if.sv -----
// ---------------------------------------------------------------------------
// TGA RLE configuration write channel
// Valid/ready register write: register index and write data.
// ---------------------------------------------------------------------------
interface tgarle_cfg_if;
    logic                                   valid;
    logic                                   ready;
    logic [tgarle_pkg::CFG_INDEX_WIDTH-1:0] index;
    logic [tgarle_pkg::CFG_DATA_WIDTH-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/tgarle_decode_core.sv -----
// ---------------------------------------------------------------------------
// TGA RLE decode core
// Per-byte decoder state machine: header skip, packet headers, pixel assembly
// and run clipping at the image pixel total. One byte per step.
// ---------------------------------------------------------------------------
`include "tga_rle_pixel_decoder_unit_assert.svh"

module tgarle_decode_core #(
    parameter int PIXEL_COUNT_WIDTH = tgarle_pkg::PIXEL_COUNT_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic [7:0]                   data_byte,
    input  logic                         start_of_image,
    input  logic [2:0]                   pixel_bytes,
    input  logic [15:0]                  header_bytes,
    input  logic [PIXEL_COUNT_WIDTH:0]   total_pixels,
    output logic                         res_valid,
    output tgarle_pkg::res_t             res
);

    localparam int CW = PIXEL_COUNT_WIDTH + 1;

    tgarle_pkg::phase_t phase_reg, phase_next;
    logic [15:0]   skip_left_reg, skip_left_next;
    logic          is_repeat_reg, is_repeat_next;
    logic [7:0]    count_left_reg, count_left_next;
    logic [1:0]    byte_index_reg, byte_index_next;
    logic [23:0]   pixel_hold_reg, pixel_hold_next;
    logic [CW-1:0] pixels_done_reg, pixels_done_next;
    logic          clip_reg, clip_next;

    tgarle_pkg::phase_t eff_phase;
    logic [15:0]   eff_skip;
    logic          eff_rep;
    logic [7:0]    eff_count;
    logic [1:0]    eff_bi;
    logic [23:0]   eff_hold;
    logic [CW-1:0] eff_done;
    logic          eff_clip;

    logic          nb4;
    logic          hdr_finished;
    logic [CW-1:0] remain;
    logic [7:0]    hdr_cnt;
    logic          hdr_clip;
    logic          do_header;
    logic          last_byte;
    logic [7:0]    run;
    logic [CW-1:0] done_sum;

    // start restarts with this byte as file byte zero
    always_comb
    begin
        eff_phase = start_of_image ? tgarle_pkg::PH_SKIP : phase_reg;
        eff_skip  = start_of_image ? header_bytes : skip_left_reg;
        eff_rep   = start_of_image ? 1'b0 : is_repeat_reg;
        eff_count = start_of_image ? 8'd0 : count_left_reg;
        eff_bi    = start_of_image ? 2'd0 : byte_index_reg;
        eff_hold  = start_of_image ? 24'd0 : pixel_hold_reg;
        eff_done  = start_of_image ? '0 : pixels_done_reg;
        eff_clip  = start_of_image ? 1'b0 : clip_reg;
    end

    assign nb4          = (pixel_bytes == tgarle_pkg::PIXEL_BYTES_RGBA);
    assign hdr_finished = (eff_done >= total_pixels);
    assign remain       = total_pixels - eff_done;
    assign hdr_cnt      = {1'b0, data_byte[6:0]} + 8'd1;
    assign hdr_clip     = (remain < CW'(hdr_cnt));
    assign last_byte    = nb4 ? (eff_bi == 2'd3) : (eff_bi >= 2'd2);
    assign run          = eff_rep ? eff_count : 8'd1;
    assign done_sum     = eff_done + CW'(run);

    always_comb
    begin
        phase_next       = eff_phase;
        skip_left_next   = eff_skip;
        is_repeat_next   = eff_rep;
        count_left_next  = eff_count;
        byte_index_next  = eff_bi;
        pixel_hold_next  = eff_hold;
        pixels_done_next = eff_done;
        clip_next        = eff_clip;
        do_header        = 1'b0;
        res_valid        = 1'b0;

        res.chan0         = eff_hold[7:0];
        res.chan1         = eff_hold[15:8];
        res.chan2         = nb4 ? eff_hold[23:16] : data_byte;
        res.chan3         = nb4 ? data_byte : tgarle_pkg::ALPHA_OPAQUE;
        res.run_length    = run;
        res.last_pixel    = (done_sum == total_pixels);
        res.overrun_error = eff_clip;

        unique case (eff_phase)
            tgarle_pkg::PH_SKIP:
            begin
                if (eff_skip != 16'd0)
                begin
                    skip_left_next = eff_skip - 16'd1;
                end
                else
                begin
                    do_header = 1'b1;
                end
            end
            tgarle_pkg::PH_HEADER:
            begin
                do_header = 1'b1;
            end
            tgarle_pkg::PH_PIXEL:
            begin
                if (!last_byte)
                begin
                    pixel_hold_next = eff_hold | (24'(data_byte) << {eff_bi, 3'b000});
                    byte_index_next = eff_bi + 2'd1;
                end
                else
                begin
                    res_valid        = step;
                    byte_index_next  = 2'd0;
                    pixel_hold_next  = 24'd0;
                    count_left_next  = eff_rep ? 8'd0 : eff_count - 8'd1;
                    pixels_done_next = done_sum;
                    if (done_sum == total_pixels)
                    begin
                        phase_next = tgarle_pkg::PH_DONE;
                    end
                    else if (count_left_next == 8'd0)
                    begin
                        phase_next = tgarle_pkg::PH_HEADER;
                    end
                end
            end
            tgarle_pkg::PH_DONE:
            begin
            end
            default:
            begin
            end
        endcase

        if (do_header)
        begin
            if (hdr_finished)
            begin
                phase_next = tgarle_pkg::PH_DONE;
            end
            else
            begin
                is_repeat_next  = data_byte[7];
                clip_next       = hdr_clip;
                count_left_next = hdr_clip ? remain[7:0] : hdr_cnt;
                byte_index_next = 2'd0;
                pixel_hold_next = 24'd0;
                phase_next      = tgarle_pkg::PH_PIXEL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= tgarle_pkg::PH_SKIP;
            skip_left_reg   <= 16'd0;
            is_repeat_reg   <= 1'b0;
            count_left_reg  <= 8'd0;
            byte_index_reg  <= 2'd0;
            pixel_hold_reg  <= 24'd0;
            pixels_done_reg <= '0;
            clip_reg        <= 1'b0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            skip_left_reg   <= skip_left_next;
            is_repeat_reg   <= is_repeat_next;
            count_left_reg  <= count_left_next;
            byte_index_reg  <= byte_index_next;
            pixel_hold_reg  <= pixel_hold_next;
            pixels_done_reg <= pixels_done_next;
            clip_reg        <= clip_next;
        end
    end

    `TGARLE_ASSERT(a_pixel_count, (phase_reg == tgarle_pkg::PH_PIXEL) |-> (count_left_reg != 8'd0), "pixel phase with no pixels left")
    `TGARLE_ASSERT_IMPL(a_res_phase, res_valid, eff_phase == tgarle_pkg::PH_PIXEL, "result outside pixel phase")
    `TGARLE_ASSERT_IMPL(a_raw_run, res_valid && !eff_rep, res.run_length == 8'd1, "raw pixel run not one")
    `TGARLE_ASSERT(a_last_done, (res_valid && res.last_pixel) |=> (phase_reg == tgarle_pkg::PH_DONE), "decoder not done after last pixel")

endmodule

// ----- rtl/tga_rle_pixel_decoder_unit.sv -----
// ---------------------------------------------------------------------------
// TGA RLE pixel decoder unit
// Decodes a run-length compressed TGA byte stream into pixel runs.
// ---------------------------------------------------------------------------
// Takes one file byte per clock while the output is not stalled and gives at
// most one pixel run per byte. An accepted byte lands in an input register,
// is decoded by the decode core once the output register can take a result,
// and its result, if any, is registered in the output register. The decode
// core updates its state once per decoded byte, which sets the rate of one
// byte per cycle; the output register lets the next byte enter while a result
// waits. Write the configuration registers only while the unit is idle.

module tga_rle_pixel_decoder_unit #(
    parameter int PIXEL_COUNT_WIDTH = tgarle_pkg::PIXEL_COUNT_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    tgarle_cfg_if.sink   cfg,
    tgarle_in_if.sink    pixin,
    tgarle_out_if.source pixout
);

    localparam int CW = PIXEL_COUNT_WIDTH + 1;

    logic [2:0]       pixel_bytes_reg;
    logic [15:0]      header_bytes_reg;
    logic [CW-1:0]    total_pixels_reg;

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_sof_reg;

    logic             out_valid_reg, out_valid_next;
    tgarle_pkg::res_t res_reg;

    logic             advance;
    logic             res_valid;
    tgarle_pkg::res_t res;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_bytes_reg  <= tgarle_pkg::PIXEL_BYTES_RST;
            header_bytes_reg <= tgarle_pkg::HEADER_BYTES_RST;
            total_pixels_reg <= CW'(tgarle_pkg::TOTAL_PIXELS_RST);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                tgarle_pkg::CFG_PIXEL_BYTES:  pixel_bytes_reg  <= cfg.data[2:0];
                tgarle_pkg::CFG_HEADER_BYTES: header_bytes_reg <= cfg.data[15:0];
                tgarle_pkg::CFG_TOTAL_PIXELS: total_pixels_reg <= CW'(cfg.data);
                default:
                begin
                end
            endcase
        end
    end

    assign advance     = in_valid_reg && (!out_valid_reg || pixout.ready);
    assign pixin.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (pixin.ready)
        begin
            in_valid_reg <= pixin.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pixin.valid && pixin.ready)
        begin
            in_byte_reg <= pixin.data_byte;
            in_sof_reg  <= pixin.start_of_image;
        end
    end

    tgarle_decode_core #(
        .PIXEL_COUNT_WIDTH (PIXEL_COUNT_WIDTH)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (advance),
        .data_byte      (in_byte_reg),
        .start_of_image (in_sof_reg),
        .pixel_bytes    (pixel_bytes_reg),
        .header_bytes   (header_bytes_reg),
        .total_pixels   (total_pixels_reg),
        .res_valid      (res_valid),
        .res            (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && pixout.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (advance && res_valid)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign pixout.valid         = out_valid_reg;
    assign pixout.chan0         = res_reg.chan0;
    assign pixout.chan1         = res_reg.chan1;
    assign pixout.chan2         = res_reg.chan2;
    assign pixout.chan3         = res_reg.chan3;
    assign pixout.run_length    = res_reg.run_length;
    assign pixout.last_pixel    = res_reg.last_pixel;
    assign pixout.overrun_error = res_reg.overrun_error;

endmodule

// ----- verif/tgarle_checker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// TGA RLE pixel decoder checker
// Watches the config, byte and pixel channels, decodes every accepted byte
// with its own copy of the decoder state and compares each pixel run, field
// by field, with the oldest expected run.
// ---------------------------------------------------------------------------
module tgarle_checker
    import tgarle_pkg::*;
#(
    parameter int PCW = PIXEL_COUNT_WIDTH_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    tgarle_cfg_if cfg,
    tgarle_in_if  pixin,
    tgarle_out_if pixout,
    output int    fail_count,
    output int    pending
);

    localparam int CW = PCW + 1;

    logic [2:0]                pix_bytes_r;
    logic [15:0]               hdr_bytes_r;
    logic [CFG_DATA_WIDTH-1:0] total_r;

    phase_t      phase;
    logic [15:0] skip_left;
    logic        rep;
    logic [7:0]  count_left;
    logic [1:0]  byte_idx;
    logic [23:0] hold;
    logic [PCW:0] done_cnt;
    logic        clipped;

    res_t expected_runs[$];

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= 50)
            $display("[%0t] tgarle mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %02h want %02h", name, got, want));
    endtask

    task automatic take_header(input logic [7:0] b);
        logic [PCW:0] tot;
        logic [PCW:0] left;
        logic [7:0]   cnt;
        tot = CW'(total_r);
        if (done_cnt >= tot)
        begin
            phase = PH_DONE;
        end
        else
        begin
            left    = tot - done_cnt;
            rep     = b[7];
            cnt     = {1'b0, b[6:0]} + 8'd1;
            clipped = 1'b0;
            if (cnt > left)
            begin
                cnt     = left[7:0];
                clipped = 1'b1;
            end
            count_left = cnt;
            byte_idx   = '0;
            hold       = '0;
            phase      = PH_PIXEL;
        end
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic sof);
        logic [2:0]   nb;
        logic [7:0]   run;
        logic [PCW:0] tot;
        res_t         r;
        nb = (pix_bytes_r == PIXEL_BYTES_RGBA) ? 3'd4 : 3'd3;
        if (sof)
        begin
            phase      = PH_SKIP;
            skip_left  = hdr_bytes_r;
            done_cnt   = '0;
            count_left = '0;
            byte_idx   = '0;
            hold       = '0;
            rep        = 1'b0;
            clipped    = 1'b0;
        end
        case (phase)
            PH_SKIP:
            begin
                if (skip_left != 16'd0)
                    skip_left = skip_left - 16'd1;
                else
                    take_header(b);
            end
            PH_HEADER: take_header(b);
            PH_DONE: ;
            default:
            begin
                if ({1'b0, byte_idx} < nb - 3'd1)
                begin
                    hold     = hold | (24'(b) << (8 * byte_idx));
                    byte_idx = byte_idx + 2'd1;
                end
                else
                begin
                    r.chan0 = hold[7:0];
                    r.chan1 = hold[15:8];
                    if (nb == 3'd4)
                    begin
                        r.chan2 = hold[23:16];
                        r.chan3 = b;
                    end
                    else
                    begin
                        r.chan2 = b;
                        r.chan3 = ALPHA_OPAQUE;
                    end
                    byte_idx = '0;
                    hold     = '0;
                    if (rep)
                    begin
                        run        = count_left;
                        count_left = '0;
                    end
                    else
                    begin
                        run        = 8'd1;
                        count_left = count_left - 8'd1;
                    end
                    done_cnt        = done_cnt + run;
                    tot             = CW'(total_r);
                    r.run_length    = run;
                    r.last_pixel    = (done_cnt == tot);
                    r.overrun_error = clipped;
                    expected_runs.push_back(r);
                    if (done_cnt == tot)
                        phase = PH_DONE;
                    else if (count_left == 8'd0)
                        phase = PH_HEADER;
                end
            end
        endcase
    endtask

    task automatic check_run();
        res_t want;
        if (expected_runs.size() == 0)
        begin
            report_mismatch($sformatf("pixel run %02h%02h%02h%02h x%0d with none expected",
                pixout.chan0, pixout.chan1, pixout.chan2, pixout.chan3,
                pixout.run_length));
        end
        else
        begin
            want = expected_runs.pop_front();
            check_field("chan0", pixout.chan0, want.chan0);
            check_field("chan1", pixout.chan1, want.chan1);
            check_field("chan2", pixout.chan2, want.chan2);
            check_field("chan3", pixout.chan3, want.chan3);
            check_field("run_length", pixout.run_length, want.run_length);
            check_field("last_pixel", 8'(pixout.last_pixel), 8'(want.last_pixel));
            check_field("overrun_error", 8'(pixout.overrun_error), 8'(want.overrun_error));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_bytes_r = PIXEL_BYTES_RST;
            hdr_bytes_r = HEADER_BYTES_RST;
            total_r     = TOTAL_PIXELS_RST;
            phase       = PH_SKIP;
            skip_left   = '0;
            rep         = 1'b0;
            count_left  = '0;
            byte_idx    = '0;
            hold        = '0;
            done_cnt    = '0;
            clipped     = 1'b0;
            expected_runs.delete();
            fail_count  = 0;
            pending     = 0;
        end
        else
        begin
            if (pixout.valid === 1'b1 && pixout.ready === 1'b1)
                check_run();
            if (cfg.valid === 1'b1 && cfg.ready === 1'b1)
            begin
                case (cfg.index)
                    CFG_PIXEL_BYTES:  pix_bytes_r = cfg.data[2:0];
                    CFG_HEADER_BYTES: hdr_bytes_r = cfg.data[15:0];
                    CFG_TOTAL_PIXELS: total_r     = cfg.data;
                    default: ;
                endcase
            end
            if (pixin.valid === 1'b1 && pixin.ready === 1'b1)
                decode_byte(pixin.data_byte, pixin.start_of_image);
            pending = expected_runs.size();
        end
    end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// TGA RLE pixel decoder testbench
// Feeds short directed byte streams, then random compressed images (mostly
// well-formed, some cut short, some noise) under several register settings,
// then directed streams for the largest header and a large total, with random
// gaps on both channels; the checker predicts and compares every pixel run.
// ---------------------------------------------------------------------------
module tb_top;
    import tgarle_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RANDOM_BYTES   = 300;

    logic clk;
    logic rst_n;

    tgarle_cfg_if cfg_bus();
    tgarle_in_if  in_bus();
    tgarle_out_if out_bus();

    int   fail_count;
    int   pending;
    logic in_fire;
    logic cfg_fire;
    int   idle_cycles;
    bit   steady;

    logic [2:0]  cur_pb;
    logic [15:0] cur_hb;
    logic [24:0] cur_tp;
    int          random_bytes;
    int          cut_left;
    bit          sof_pending;

    tga_rle_pixel_decoder_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus),
        .pixin  (in_bus),
        .pixout (out_bus)
    );

    tgarle_checker #(.PCW(PIXEL_COUNT_WIDTH_DEF)) chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_bus),
        .pixin      (in_bus),
        .pixout     (out_bus),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        in_fire  <= in_bus.valid && in_bus.ready;
        cfg_fire <= cfg_bus.valid && cfg_bus.ready;
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else if ((in_bus.valid && in_bus.ready) || (cfg_bus.valid && cfg_bus.ready)
                 || (out_bus.valid && out_bus.ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("** tga_rle_pixel_decoder_unit: FAILED **");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(11, 40);
    endfunction

    // pixel sink: random back-pressure
    initial
    begin
        int hold_cnt;
        hold_cnt = 0;
        out_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (steady)
            begin
                out_bus.ready = 1'b1;
            end
            else if (hold_cnt != 0)
            begin
                hold_cnt--;
            end
            else
            begin
                out_bus.ready = ~out_bus.ready;
                hold_cnt = out_bus.ready ? $urandom_range(0, 15) : pick_gap();
            end
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic sof);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_bus.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_bus.valid          = 1'b1;
        in_bus.data_byte      = b;
        in_bus.start_of_image = sof;
        do @(negedge clk); while (in_fire !== 1'b1);
    endtask

    task automatic set_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] val);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = idx;
        cfg_bus.data  = val;
        do @(negedge clk); while (cfg_fire !== 1'b1);
        cfg_bus.valid = 1'b0;
        case (idx)
            CFG_PIXEL_BYTES:  cur_pb = val[2:0];
            CFG_HEADER_BYTES: cur_hb = val[15:0];
            CFG_TOTAL_PIXELS: cur_tp = val;
            default: ;
        endcase
    endtask

    task automatic wait_for_runs();
        in_bus.valid = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic drain();
        wait_for_runs();
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic put_byte(input logic [7:0] b);
        logic sof;
        sof = sof_pending;
        sof_pending = 1'b0;
        if (cut_left != 0)
        begin
            cut_left--;
            random_bytes++;
            push_byte(b, sof);
        end
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 8);
        repeat (n)
        begin
            random_bytes++;
            push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end
    endtask

    task automatic send_image(input bit broken);
        int         nb;
        int         remain;
        int         cnt;
        int         lim;
        int         r;
        int         pk;
        bit         rep;
        logic [6:0] c7;
        nb          = (cur_pb == PIXEL_BYTES_RGBA) ? 4 : 3;
        remain      = (cur_tp > 400) ? $urandom_range(20, 300) : int'(cur_tp);
        cut_left    = broken ? $urandom_range(1, 20) : 32'h4000_0000;
        sof_pending = 1'b1;
        for (int i = 0; i < int'(cur_hb); i++)
            put_byte(8'($urandom_range(0, 255)));
        pk = 0;
        while (remain > 0 && pk < 40)
        begin
            rep = 1'($urandom_range(0, 1));
            r   = $urandom_range(0, 99);
            if (rep)
            begin
                lim = (remain < 128) ? remain : 128;
                if (r < 10)
                    cnt = remain + $urandom_range(1, 3);
                else if (r < 20)
                    cnt = 128;
                else
                    cnt = $urandom_range(1, lim);
                if (cnt > 128)
                    cnt = 128;
            end
            else
            begin
                lim = (remain < 4) ? remain : 4;
                cnt = (r < 10) ? remain + $urandom_range(1, 2) : $urandom_range(1, lim);
                if (cnt > 8)
                    cnt = $urandom_range(1, 4);
            end
            c7 = 7'(cnt - 1);
            put_byte({rep, c7});
            repeat (rep ? nb : cnt * nb)
                put_byte(8'($urandom_range(0, 255)));
            remain = (cnt >= remain) ? 0 : remain - cnt;
            pk++;
        end
        if (sof_pending)
            put_byte(8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0)
            put_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic random_config();
        int r;
        steady = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 1))
            set_reg(CFG_PIXEL_BYTES, CFG_DATA_WIDTH'($urandom_range(0, 1) ?
                    PIXEL_BYTES_RGBA : PIXEL_BYTES_RST));
        if ($urandom_range(0, 2) != 0)
        begin
            r = $urandom_range(0, 99);
            set_reg(CFG_HEADER_BYTES, CFG_DATA_WIDTH'((r < 75) ? $urandom_range(0, 3)
                                                               : $urandom_range(4, 24)));
        end
        if ($urandom_range(0, 2) != 0)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
                set_reg(CFG_TOTAL_PIXELS, CFG_DATA_WIDTH'(0));
            else if (r < 15)
                set_reg(CFG_TOTAL_PIXELS, CFG_DATA_WIDTH'(1));
            else if (r < 95)
                set_reg(CFG_TOTAL_PIXELS, CFG_DATA_WIDTH'($urandom_range(2, 24)));
            else
                set_reg(CFG_TOTAL_PIXELS, CFG_DATA_WIDTH'($urandom_range(100, 400)));
        end
    endtask

    initial
    begin
        int r;
        rst_n                 = 1'b0;
        steady                = 1'b0;
        in_bus.valid          = 1'b0;
        in_bus.data_byte      = '0;
        in_bus.start_of_image = 1'b0;
        cfg_bus.valid         = 1'b0;
        cfg_bus.index         = CFG_PIXEL_BYTES;
        cfg_bus.data          = '0;
        cur_pb                = PIXEL_BYTES_RST;
        cur_hb                = HEADER_BYTES_RST;
        cur_tp                = TOTAL_PIXELS_RST;
        random_bytes          = 0;
        cut_left              = 0;
        sof_pending           = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // bytes with no start after reset: decoded with no header skip
        set_reg(CFG_TOTAL_PIXELS, CFG_DATA_WIDTH'(3));
        push_byte(8'h81, 1'b0);
        push_byte(8'hAA, 1'b0);
        push_byte(8'hBB, 1'b0);
        push_byte(8'hCC, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h7F, 1'b0);
        push_byte(8'h12, 1'b0);

        // zero header, rgba, repeat 128 clipped to the total
        drain();
        set_reg(CFG_HEADER_BYTES, CFG_DATA_WIDTH'(0));
        set_reg(CFG_PIXEL_BYTES, CFG_DATA_WIDTH'(PIXEL_BYTES_RGBA));
        set_reg(CFG_TOTAL_PIXELS, CFG_DATA_WIDTH'(2));
        push_byte(8'hFF, 1'b1);
        push_byte(8'h01, 1'b0);
        push_byte(8'h02, 1'b0);
        push_byte(8'h03, 1'b0);
        push_byte(8'h04, 1'b0);
        push_byte(8'h55, 1'b0);

        // pixel size changed mid-pixel
        drain();
        set_reg(CFG_HEADER_BYTES, CFG_DATA_WIDTH'(1));
        set_reg(CFG_TOTAL_PIXELS, CFG_DATA_WIDTH'(6));
        push_byte(8'h99, 1'b1);
        push_byte(8'h01, 1'b0);
        push_byte(8'h10, 1'b0);
        push_byte(8'h20, 1'b0);
        push_byte(8'h30, 1'b0);
        push_byte(8'h40, 1'b0);
        push_byte(8'hA1, 1'b0);
        push_byte(8'hB2, 1'b0);
        push_byte(8'hC3, 1'b0);
        drain();
        set_reg(CFG_PIXEL_BYTES, CFG_DATA_WIDTH'(PIXEL_BYTES_RST));
        push_byte(8'hD4, 1'b0);

        // total lowered below the pixels already done
        drain();
        set_reg(CFG_TOTAL_PIXELS, CFG_DATA_WIDTH'(1));
        push_byte(8'h80, 1'b0);
        push_byte(8'h33, 1'b0);

        // zero total
        drain();
        set_reg(CFG_HEADER_BYTES, CFG_DATA_WIDTH'(0));
        set_reg(CFG_TOTAL_PIXELS, CFG_DATA_WIDTH'(0));
        push_byte(8'h80, 1'b1);
        push_byte(8'h00, 1'b0);

        random_bytes = 0;
        while (random_bytes < RANDOM_BYTES)
        begin
            drain();
            random_config();
            repeat ($urandom_range(1, 3))
            begin
                if ($urandom_range(0, 9) == 0)
                    wait_for_runs();
                r = $urandom_range(0, 99);
                if (r < 12)
                    send_noise();
                else
                    send_image(r < 25);
            end
        end

        // largest header: every byte after the start is skipped
        drain();
        steady = 1'b1;
        set_reg(CFG_HEADER_BYTES, CFG_DATA_WIDTH'(16'hFFFF));
        set_reg(CFG_TOTAL_PIXELS, CFG_DATA_WIDTH'(2));
        push_byte(8'h81, 1'b1);
        repeat (16)
            push_byte(8'($urandom_range(0, 255)), 1'b0);

        // large total of 2**24 pixels
        drain();
        steady = 1'b0;
        set_reg(CFG_HEADER_BYTES, CFG_DATA_WIDTH'(0));
        set_reg(CFG_TOTAL_PIXELS, 25'd16777216);
        send_image(1'b0);
        send_image(1'b0);

        drain();
        if (fail_count == 0 && pending == 0)
            $display("** tga_rle_pixel_decoder_unit: PASSED **");
        else
            $display("** tga_rle_pixel_decoder_unit: FAILED **");
        $finish;
    end

endmodule

// ----- tga_rle_pixel_decoder_unit.f -----
+incdir+rtl
rtl/tgarle_pkg.sv
rtl/tgarle_in_if.sv
rtl/tgarle_out_if.sv
rtl/tgarle_cfg_if.sv
rtl/tgarle_decode_core.sv
rtl/tga_rle_pixel_decoder_unit.sv
verif/tgarle_checker.sv
verif/tb_top.sv
